FILE: rtl/core/cpsds_pkg.sv
package cpsds_pkg;

    localparam int NUM_SEGMENTS = 40;
    localparam int MAX_NUMBER   = 9999;

    localparam logic [2:0] KIND_SCAN    = 3'd0;
    localparam logic [2:0] KIND_NUMBER  = 3'd1;
    localparam logic [2:0] KIND_MODE    = 3'd2;
    localparam logic [2:0] KIND_BATTERY = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    localparam int SEG_MODE0    = 37;
    localparam int SEG_MODE1    = 38;
    localparam int SEG_CASE_LO  = 28;
    localparam int SEG_BAR_FULL = 32;
    localparam int SEG_BAR_MID  = 33;
    localparam int SEG_BAR_LOW  = 34;

    // reciprocal of ten, exact for quotients of values up to 9999
    localparam logic [12:0] RECIP_TEN = 13'd6554;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic digit_step;
        logic scan_bit;
        logic load_out;
    } cpsds_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       num_ok;
        logic       digit_last;
    } cpsds_status_t;

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // {high pin, low pin}
    function automatic logic [5:0] pin_pair(input logic [5:0] s);
        logic [5:0] p;
        case (s)
            6'd0:  p = {3'd0, 3'd1};
            6'd1:  p = {3'd0, 3'd2};
            6'd2:  p = {3'd3, 3'd0};
            6'd3:  p = {3'd4, 3'd0};
            6'd4:  p = {3'd0, 3'd3};
            6'd5:  p = {3'd1, 3'd0};
            6'd6:  p = {3'd2, 3'd0};
            6'd7:  p = {3'd1, 3'd2};
            6'd8:  p = {3'd1, 3'd3};
            6'd9:  p = {3'd4, 3'd1};
            6'd10: p = {3'd1, 3'd5};
            6'd11: p = {3'd1, 3'd4};
            6'd12: p = {3'd2, 3'd1};
            6'd13: p = {3'd3, 3'd1};
            6'd14: p = {3'd4, 3'd3};
            6'd15: p = {3'd2, 3'd4};
            6'd16: p = {3'd3, 3'd4};
            6'd17: p = {3'd5, 3'd0};
            6'd18: p = {3'd5, 3'd2};
            6'd19: p = {3'd3, 3'd2};
            6'd20: p = {3'd4, 3'd2};
            6'd21: p = {3'd6, 3'd5};
            6'd22: p = {3'd5, 3'd6};
            6'd23: p = {3'd4, 3'd5};
            6'd24: p = {3'd5, 3'd3};
            6'd25: p = {3'd3, 3'd5};
            6'd26: p = {3'd5, 3'd4};
            6'd27: p = {3'd4, 3'd6};
            6'd28: p = {3'd6, 3'd2};
            6'd29: p = {3'd2, 3'd6};
            6'd30: p = {3'd2, 3'd5};
            6'd31: p = {3'd0, 3'd5};
            6'd32: p = {3'd0, 3'd6};
            6'd33: p = {3'd1, 3'd6};
            6'd34: p = {3'd3, 3'd6};
            6'd35: p = {3'd6, 3'd0};
            6'd36: p = {3'd6, 3'd4};
            6'd37: p = {3'd0, 3'd4};
            6'd38: p = {3'd6, 3'd1};
            6'd39: p = {3'd5, 3'd1};
            default: p = {3'd0, 3'd0};
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/cpsds_req_if.sv
interface cpsds_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [13:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

FILE: rtl/core/cpsds_rsp_if.sv
interface cpsds_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] pin_drive_enable;
    logic [6:0] pin_drive_high;
    logic [5:0] lit_segment;
    logic       lit_valid;

    modport source (output valid, output pin_drive_enable, output pin_drive_high,
                    output lit_segment, output lit_valid, input ready);
    modport sink (input valid, input pin_drive_enable, input pin_drive_high,
                  input lit_segment, input lit_valid, output ready);
endinterface

FILE: rtl/core/cpsds_ctrl.sv
module cpsds_ctrl
    import cpsds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  cpsds_status_t status,
    output cpsds_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_DIGIT = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.kind == KIND_NUMBER)
                    state_next = status.num_ok ? ST_DIGIT : ST_EMIT;
                else if (status.kind == KIND_SCAN)
                    state_next = ST_SCAN;
                else
                    state_next = ST_EMIT;
            end
            ST_DIGIT:
            begin
                cmd.digit_step = 1'b1;
                if (status.digit_last)
                    state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                cmd.scan_bit = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: rtl/core/cpsds_dp.sv
module cpsds_dp
    import cpsds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cpsds_cmd_t    cmd,
    output cpsds_status_t status,
    input  logic [2:0]    req_kind,
    input  logic [13:0]   req_value,
    output logic [6:0]    pin_drive_enable,
    output logic [6:0]    pin_drive_high,
    output logic [5:0]    lit_segment,
    output logic          lit_valid
);

    logic [39:0] enables_reg;
    logic [39:0] snapshot_reg;
    logic [5:0]  cur_seg_reg;
    logic        driven_reg;
    logic [2:0]  kind_reg;
    logic [13:0] num_reg;
    logic [1:0]  digit_reg;
    logic [2:0]  group_reg;
    logic        snap_nz_reg;

    logic [6:0]  pde_reg;
    logic [6:0]  pdh_reg;
    logic [5:0]  lit_seg_reg;
    logic        lit_valid_reg;

    logic [26:0] prod;
    logic [9:0]  quot;
    logic [13:0] quot_x10;
    logic [3:0]  rem_digit;
    logic        show;
    logic [5:0]  digit_base;

    logic [2:0]  group_sel;
    logic        group_nz;
    logic [7:0]  group_bits;
    logic [2:0]  bit_sel;
    logic [5:0]  seg_sel;
    logic [39:0] snap_after;

    logic [5:0]  pair;
    logic [6:0]  hi_mask;
    logic [6:0]  lo_mask;

    assign status.kind       = kind_reg;
    assign status.num_ok     = (num_reg <= 14'(MAX_NUMBER));
    assign status.digit_last = (digit_reg == 2'd0);

    // one decimal digit per step: quotient by reciprocal, remainder by shift-add
    assign prod       = 27'(num_reg) * 27'(RECIP_TEN);
    assign quot       = prod[25:16];
    assign quot_x10   = (14'(quot) << 3) + (14'(quot) << 1);
    assign rem_digit  = 4'(num_reg - quot_x10);
    assign show       = (num_reg != 14'd0) || (digit_reg == 2'd3);
    assign digit_base = 6'(digit_reg) * 6'd7;

    always_comb
    begin
        group_nz  = 1'b1;
        if (snapshot_reg[39:32] != 8'd0)
            group_sel = 3'd4;
        else if (snapshot_reg[31:24] != 8'd0)
            group_sel = 3'd3;
        else if (snapshot_reg[23:16] != 8'd0)
            group_sel = 3'd2;
        else if (snapshot_reg[15:8] != 8'd0)
            group_sel = 3'd1;
        else
        begin
            group_sel = 3'd0;
            group_nz  = (snapshot_reg[7:0] != 8'd0);
        end
    end

    always_comb
    begin
        group_bits = snapshot_reg[{group_reg, 3'b000} +: 8];
        bit_sel    = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (group_bits[i])
                bit_sel = 3'(i);
        end
    end

    assign seg_sel    = {group_reg, bit_sel};
    assign snap_after = snap_nz_reg ? (snapshot_reg & ~(40'd1 << seg_sel)) : snapshot_reg;

    assign pair    = pin_pair(cur_seg_reg);
    assign hi_mask = 7'd1 << pair[5:3];
    assign lo_mask = 7'd1 << pair[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg  <= '0;
            snapshot_reg <= '0;
            cur_seg_reg  <= '0;
            driven_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (kind_reg)
                    KIND_MODE:
                    begin
                        enables_reg[SEG_MODE1] <= (num_reg != 14'd0);
                        enables_reg[SEG_MODE0] <= (num_reg == 14'd0);
                    end
                    KIND_BATTERY:
                    begin
                        enables_reg[SEG_CASE_LO +: 4] <= 4'hF;
                        enables_reg[SEG_BAR_FULL]     <= (num_reg == 14'd3);
                        enables_reg[SEG_BAR_MID]      <= (num_reg == 14'd2) ||
                                                         (num_reg == 14'd3);
                        enables_reg[SEG_BAR_LOW]      <= (num_reg >= 14'd1) &&
                                                         (num_reg <= 14'd3);
                    end
                    KIND_CLEAR:
                    begin
                        enables_reg  <= '0;
                        snapshot_reg <= '0;
                        cur_seg_reg  <= '0;
                        driven_reg   <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.digit_step)
                enables_reg[digit_base +: 7] <= show ? glyph(rem_digit) : 7'd0;
            if (cmd.scan_bit)
            begin
                if (snap_nz_reg)
                begin
                    cur_seg_reg <= seg_sel;
                    driven_reg  <= 1'b1;
                end
                snapshot_reg <= (snap_after == 40'd0) ? enables_reg : snap_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg  <= req_kind;
            num_reg   <= req_value;
            digit_reg <= 2'd3;
        end
        if (cmd.digit_step)
        begin
            num_reg   <= 14'(quot);
            digit_reg <= digit_reg - 2'd1;
        end
        if (cmd.exec)
        begin
            group_reg   <= group_sel;
            snap_nz_reg <= group_nz;
        end
        if (cmd.load_out)
        begin
            pde_reg       <= driven_reg ? (hi_mask | lo_mask) : 7'd0;
            pdh_reg       <= driven_reg ? hi_mask : 7'd0;
            lit_seg_reg   <= driven_reg ? cur_seg_reg : 6'd0;
            lit_valid_reg <= driven_reg;
        end
    end

    assign pin_drive_enable = pde_reg;
    assign pin_drive_high   = pdh_reg;
    assign lit_segment      = lit_seg_reg;
    assign lit_valid        = lit_valid_reg;

endmodule

FILE: rtl/core/charlieplex_segment_display_scanner_unit.sv
// Channel   Role   Payload
// request   sink   kind, value
// result    source pin_drive_enable, pin_drive_high, lit_segment, lit_valid
//
// One request at a time. Scan tick: idle, exec, scan, emit (leading-one search
// split into a byte-group pick in exec and a bit pick in scan). Number write:
// one decimal digit per cycle via the divide-by-ten unit; out of range and other
// writes skip the digits. A pending result holds while the next request is taken.
// Reset clears enables, snapshot, lit segment, result valid; not the pin outputs.
module charlieplex_segment_display_scanner_unit
    import cpsds_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    cpsds_req_if.sink   request,
    cpsds_rsp_if.source result
);

    cpsds_cmd_t    cmd;
    cpsds_status_t status;

    cpsds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (result.valid),
        .rsp_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cpsds_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .req_kind         (request.kind),
        .req_value        (request.value),
        .pin_drive_enable (result.pin_drive_enable),
        .pin_drive_high   (result.pin_drive_high),
        .lit_segment      (result.lit_segment),
        .lit_valid        (result.lit_valid)
    );

endmodule
